[src/ntcb_pkg.sv]
// Shared types and constants for the NTC beta-equation temperature converter.
// Used by every module of the block; depends on nothing.
package ntcb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OHM_W      = 20;
    localparam int BETA_W     = 14;
    localparam int T0_W       = 15;

    localparam int LOG_K_W    = 5;
    localparam int LOG_FRAC   = 28;
    localparam int LOG_W      = LOG_K_W + LOG_FRAC;
    localparam int LOG_LAT    = LOG_FRAC + 1;

    localparam int DIV_BITS   = 16;
    localparam int DIV_A_W    = 63;
    localparam int DIV_B_W    = 50;

    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [15:0] KELVIN_CENTI = 16'd27315;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIES_A  = 3'd0,
        CFG_NOMINAL_A = 3'd1,
        CFG_SERIES_B  = 3'd2,
        CFG_NOMINAL_B = 3'd3,
        CFG_BETA      = 3'd4,
        CFG_T0        = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic fault;
    } t_tag;

endpackage

[src/ntc_beta_temperature.sv]
// Top level of the NTC beta-equation converter: config registers, log sum, scaling, output.
// Depends on ntcb_pkg, ntcb_log2 and ntcb_div.
//
//   channel  ports                                        handshake
//   input    start, i_mode, i_sample                       start && !busy
//   config   i_cfg_valid, i_cfg_index, i_cfg_data          i_cfg_valid && o_cfg_ready
//   result   o_temp_centi_c, o_fault, o_saturated          o_strobe, one cycle
//
// One word is accepted in every cycle; busy is always low and o_cfg_ready always high.
// Each result passes, in order, through the input register, one normalize and 28 squaring
// stages of the logs, 5 scaling stages, 16 divider stages and the output register.
// Reset clears the config registers to their defaults and all valid bits.
// The receiver cannot stall, so the pipeline never holds.
module ntc_beta_temperature #(
    parameter int ADC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [ADC_BITS-1:0]            i_sample,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ntcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ntcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_strobe,
    output logic signed [15:0]             o_temp_centi_c,
    output logic                           o_fault,
    output logic                           o_saturated
);

    localparam int OW = ntcb_pkg::OHM_W;
    localparam int LW = ntcb_pkg::LOG_W;
    localparam int LL = ntcb_pkg::LOG_LAT;
    localparam int LAT = 52;

    logic [OW-1:0]                 r_ser_a, r_nom_a, r_ser_b, r_nom_b;
    logic [ntcb_pkg::BETA_W-1:0]   r_beta;
    logic [ntcb_pkg::T0_W-1:0]     r_t0;
    logic [20:0]                   r_beta100;
    logic [36:0]                   r_nbase;
    logic signed [16:0]            w_k0;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_a <= 20'd10000;
            r_nom_a <= 20'd10000;
            r_ser_b <= 20'd22000;
            r_nom_b <= 20'd20000;
            r_beta  <= 14'd3950;
            r_t0    <= 15'd2500;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ntcb_pkg::CFG_SERIES_A:  r_ser_a <= i_cfg_data;
                ntcb_pkg::CFG_NOMINAL_A: r_nom_a <= i_cfg_data;
                ntcb_pkg::CFG_SERIES_B:  r_ser_b <= i_cfg_data;
                ntcb_pkg::CFG_NOMINAL_B: r_nom_b <= i_cfg_data;
                ntcb_pkg::CFG_BETA:      r_beta  <= i_cfg_data[ntcb_pkg::BETA_W-1:0];
                ntcb_pkg::CFG_T0:        r_t0    <= i_cfg_data[ntcb_pkg::T0_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_k0 = $signed({{2{r_t0[14]}}, r_t0}) + $signed({1'b0, ntcb_pkg::KELVIN_CENTI});

    always_ff @(posedge i_clk) begin
        r_beta100 <= 21'(r_beta) * 21'd100;
        r_nbase   <= 37'(r_beta100) * 37'(w_k0[15:0]);
    end

    // Input stage.
    ntcb_pkg::t_tag        r_s0_tag;
    logic [OW-1:0]         r_op_ser, r_op_nom;
    logic [ADC_BITS-1:0]   r_op_smp, r_op_lo;
    logic [OW-1:0]         w_ser, w_nom;

    assign w_ser = i_mode ? r_ser_b : r_ser_a;
    assign w_nom = i_mode ? r_nom_b : r_nom_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag <= '0;
        end else begin
            r_s0_tag.valid <= start && !busy;
            r_s0_tag.fault <= (i_sample == '0) || (&i_sample) || (w_ser == '0)
                              || (w_nom == '0) || (r_beta == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_ser <= w_ser;
        r_op_nom <= w_nom;
        r_op_smp <= i_sample;
        r_op_lo  <= {ADC_BITS{1'b1}} - i_sample;
    end

    // Logarithms.
    logic [LW-1:0] w_lg_ser, w_lg_nom, w_lg_smp, w_lg_lo;

    ntcb_log2 #(.IN_W(OW)) u_log_ser (.i_clk(i_clk), .i_x(r_op_ser), .o_log(w_lg_ser));
    ntcb_log2 #(.IN_W(OW)) u_log_nom (.i_clk(i_clk), .i_x(r_op_nom), .o_log(w_lg_nom));
    ntcb_log2 #(.IN_W(ADC_BITS)) u_log_smp (.i_clk(i_clk), .i_x(r_op_smp), .o_log(w_lg_smp));
    ntcb_log2 #(.IN_W(ADC_BITS)) u_log_lo (.i_clk(i_clk), .i_x(r_op_lo), .o_log(w_lg_lo));

    ntcb_pkg::t_tag r_lg_tag [0:LL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LL; j++) begin
                r_lg_tag[j] <= '0;
            end
        end else begin
            r_lg_tag[0] <= r_s0_tag;
            for (int j = 1; j < LL; j++) begin
                r_lg_tag[j] <= r_lg_tag[j-1];
            end
        end
    end

    // Scaling stages.
    ntcb_pkg::t_tag     r_p1_tag, r_p2_tag, r_p3_tag, r_p4_tag, r_p5_tag;
    logic signed [34:0] r_l2;
    logic               r_p2_neg;
    logic [46:0]        r_ph, r_pl;
    logic signed [30:0] r_lq;
    logic signed [49:0] r_d;
    logic [62:0]        r_a;
    logic [49:0]        r_b;
    logic [34:0]        w_abs;
    logic [63:0]        w_prod;
    logic [29:0]        w_lnmag;
    logic signed [47:0] w_lqk;
    logic [44:0]        w_bterm;
    logic               w_dbad;

    assign w_abs   = r_l2[34] ? 35'(-r_l2) : 35'(r_l2);
    assign w_prod  = {r_ph, 17'd0} + 64'(r_pl) + (64'd1 << 33);
    assign w_lnmag = w_prod[63:34];
    assign w_lqk   = r_lq * w_k0;
    assign w_bterm = {r_beta100, 24'd0};
    assign w_dbad  = r_d[49] || (r_d == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tag <= '0;
            r_p2_tag <= '0;
            r_p3_tag <= '0;
            r_p4_tag <= '0;
            r_p5_tag <= '0;
        end else begin
            r_p1_tag <= r_lg_tag[LL-1];
            r_p2_tag <= r_p1_tag;
            r_p3_tag <= r_p2_tag;
            r_p4_tag <= r_p3_tag;
            r_p5_tag.valid <= r_p4_tag.valid;
            r_p5_tag.fault <= r_p4_tag.fault || w_dbad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2     <= $signed(35'(w_lg_ser) + 35'(w_lg_lo) - 35'(w_lg_smp) - 35'(w_lg_nom));
        r_p2_neg <= r_l2[34];
        r_ph     <= 47'(w_abs[33:17]) * 47'(ntcb_pkg::LN2_Q30);
        r_pl     <= 47'(w_abs[16:0]) * 47'(ntcb_pkg::LN2_Q30);
        r_lq     <= r_p2_neg ? -$signed({1'b0, w_lnmag}) : $signed({1'b0, w_lnmag});
        r_d      <= 50'(w_lqk) + $signed(50'(w_bterm));
        r_a      <= {r_nbase, 25'd0} + 63'(r_d[48:0]);
        r_b      <= {r_d[48:0], 1'b0};
    end

    // Division and output.
    ntcb_pkg::t_tag                w_dv_tag;
    logic [ntcb_pkg::DIV_BITS-1:0] w_q;
    logic                          w_ovf;
    logic signed [17:0]            w_t;

    ntcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_p5_tag),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_tag   (w_dv_tag),
        .o_q     (w_q),
        .o_ovf   (w_ovf)
    );

    assign w_t = $signed({2'b00, w_q}) - $signed({2'b00, ntcb_pkg::KELVIN_CENTI});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_dv_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_tag.fault) begin
            o_temp_centi_c <= '0;
            o_fault        <= 1'b1;
            o_saturated    <= 1'b0;
        end else if (w_ovf || (w_t > 18'sd32767)) begin
            o_temp_centi_c <= 16'sd32767;
            o_fault        <= 1'b0;
            o_saturated    <= 1'b1;
        end else begin
            o_temp_centi_c <= w_t[15:0];
            o_fault        <= 1'b0;
            o_saturated    <= 1'b0;
        end
    end

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_fault) |-> (o_temp_centi_c == 16'sd0 && !o_saturated))
        else $error("faulted word carries a nonzero temperature");

    a_sat_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_temp_centi_c == 16'sd32767))
        else $error("saturated word is not clamped to the upper bound");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted word did not strobe after the pipeline latency");

    a_zero_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_sample == '0) |-> ##LAT (o_strobe && o_fault))
        else $error("zero sample did not produce a fault");

endmodule

[src/ntcb_log2.sv]
// Pipelined base-2 logarithm in Q28: one normalize stage, then one squaring stage per bit.
// Depends on ntcb_pkg for the fraction width and output width.
module ntcb_log2 #(
    parameter int IN_W = 20
) (
    input  logic                       i_clk,
    input  logic [IN_W-1:0]            i_x,
    output logic [ntcb_pkg::LOG_W-1:0] o_log
);

    localparam int FR = ntcb_pkg::LOG_FRAC;
    localparam int KW = ntcb_pkg::LOG_K_W;

    logic [KW-1:0] r_k [0:FR];
    logic [30:0]   r_m [0:FR];
    logic [FR-1:0] r_f [0:FR];
    logic [KW-1:0] n_k;
    logic [30:0]   n_m;

    always_comb begin
        n_k = '0;
        for (int b = 1; b < IN_W; b++) begin
            if (i_x[b]) begin
                n_k = KW'(b);
            end
        end
        n_m = 31'(i_x) << (KW'(30) - n_k);
    end

    always_ff @(posedge i_clk) begin
        r_k[0] <= n_k;
        r_m[0] <= n_m;
        r_f[0] <= '0;
    end

    for (genvar g = 0; g < FR; g++) begin : g_sq
        localparam int BIT = FR - 1 - g;
        logic [61:0] w_sq;
        logic [31:0] w_t;
        assign w_sq = 62'(r_m[g]) * 62'(r_m[g]);
        assign w_t  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            r_k[g+1] <= r_k[g];
            if (w_t[31]) begin
                r_m[g+1] <= w_t[31:1];
                r_f[g+1] <= r_f[g] | (FR'(1) << BIT);
            end else begin
                r_m[g+1] <= w_t[30:0];
                r_f[g+1] <= r_f[g];
            end
        end
    end

    assign o_log = {r_k[FR], r_f[FR]};

endmodule

[src/ntcb_div.sv]
// Pipelined restoring divider producing a 16-bit quotient, one bit per stage.
// Flags quotients of 2^16 or more; depends on ntcb_pkg for widths and the tag type.
module ntcb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ntcb_pkg::t_tag               i_tag,
    input  logic [ntcb_pkg::DIV_A_W-1:0] i_a,
    input  logic [ntcb_pkg::DIV_B_W-1:0] i_b,
    output ntcb_pkg::t_tag               o_tag,
    output logic [ntcb_pkg::DIV_BITS-1:0] o_q,
    output logic                         o_ovf
);

    localparam int NB = ntcb_pkg::DIV_BITS;
    localparam int AW = ntcb_pkg::DIV_A_W;
    localparam int BW = ntcb_pkg::DIV_B_W;
    localparam int CW = BW + NB + 1;

    ntcb_pkg::t_tag s_tag [0:NB];
    logic [AW-1:0]  s_rem [0:NB];
    logic [BW-1:0]  s_b   [0:NB];
    logic [NB-1:0]  s_q   [0:NB];
    logic           s_ovf [0:NB];

    assign s_tag[0] = i_tag;
    assign s_rem[0] = i_a;
    assign s_b[0]   = i_b;
    assign s_q[0]   = '0;
    assign s_ovf[0] = CW'(i_a) >= CW'({i_b, NB'(0)});

    for (genvar g = 0; g < NB; g++) begin : g_stage
        localparam int BIT = NB - 1 - g;
        ntcb_pkg::t_tag r_tag;
        logic [AW-1:0]  r_rem;
        logic [BW-1:0]  r_b;
        logic [NB-1:0]  r_q;
        logic           r_ovf;
        logic [CW-1:0]  w_sh;
        logic           w_ge;

        assign w_sh = CW'(s_b[g]) << BIT;
        assign w_ge = CW'(s_rem[g]) >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else begin
                r_tag <= s_tag[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_b   <= s_b[g];
            r_ovf <= s_ovf[g];
            if (w_ge) begin
                r_rem <= s_rem[g] - w_sh[AW-1:0];
                r_q   <= s_q[g] | (NB'(1) << BIT);
            end else begin
                r_rem <= s_rem[g];
                r_q   <= s_q[g];
            end
        end

        assign s_tag[g+1] = r_tag;
        assign s_rem[g+1] = r_rem;
        assign s_b[g+1]   = r_b;
        assign s_q[g+1]   = r_q;
        assign s_ovf[g+1] = r_ovf;
    end

    assign o_tag = s_tag[NB];
    assign o_q   = s_q[NB];
    assign o_ovf = s_ovf[NB];

endmodule

[tb/tb_top.sv]
// Self-checking testbench for ntc_beta_temperature: directed, register and random tests.
// Depends on ntcb_pkg and the block; predicts each conversion in fixed point.
`timescale 1ns / 1ps

module tb_top;

    localparam int          FULL_CODE  = 4095;
    localparam int          DRAIN_CYC  = 60;
    localparam logic [2:0]  IDX_SPARE6 = 3'd6;
    localparam logic [2:0]  IDX_SPARE7 = 3'd7;

    typedef struct {
        logic signed [15:0] temp;
        logic               fault;
        logic               sat;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_mode = 1'b0;
    logic [11:0]           i_sample = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [ntcb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ntcb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic signed [15:0]    o_temp_centi_c;
    logic                  o_fault;
    logic                  o_saturated;

    logic [19:0] ser_a, nom_a, ser_b, nom_b;
    logic [13:0] beta_k;
    logic [14:0] t0_centi;

    t_reading pending_readings[$];
    int       n_errors = 0;
    int       n_words = 0;
    int       n_results = 0;
    int       n_faults = 0;
    int       n_sats = 0;

    ntc_beta_temperature DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_sample(i_sample), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_temp_centi_c(o_temp_centi_c), .o_fault(o_fault),
        .o_saturated(o_saturated)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint log2_fix(longint unsigned x);
        longint unsigned k, m, frac;
        k = 0;
        frac = 0;
        while (k < 30 && (x >> (k + 1)) != 0) k++;
        m = x << (30 - k);
        for (int i = 0; i < 28; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (27 - i));
            end
        end
        return longint'((k << 28) | frac);
    endfunction

    function automatic t_reading convert_sample(logic mode, logic [11:0] smp);
        t_reading r;
        longint unsigned ser, nom, mag, lnmag, n, q;
        longint t0, k0, l2, lq, d, t;
        r.temp = '0;
        r.fault = 1'b1;
        r.sat = 1'b0;
        ser = mode ? ser_b : ser_a;
        nom = mode ? nom_b : nom_a;
        if (smp == 0 || smp >= FULL_CODE || ser == 0 || nom == 0 || beta_k == 0) return r;
        t0 = longint'($signed(t0_centi));
        k0 = t0 + 27315;
        l2 = log2_fix(ser) + log2_fix(FULL_CODE - smp) - log2_fix(smp) - log2_fix(nom);
        mag = (l2 < 0) ? longint'(-l2) : l2;
        lnmag = (mag * 64'd744261118 + (64'd1 << 33)) >> 34;
        lq = (l2 < 0) ? -longint'(lnmag) : longint'(lnmag);
        d = lq * k0 + longint'((64'd100 * beta_k) << 24);
        if (d <= 0) return r;
        n = (64'd100 * beta_k * longint'(k0)) << 24;
        q = (64'd2 * n + longint'(d)) / (64'd2 * longint'(d));
        t = longint'(q) - 27315;
        r.fault = 1'b0;
        if (t > 32767) begin
            t = 32767;
            r.sat = 1'b1;
        end else if (t < -32768) begin
            t = -32768;
            r.sat = 1'b1;
        end
        r.temp = t[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_readings.push_back(convert_sample(i_mode, i_sample));
            n_words++;
        end
    end

    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_strobe) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result temp %0d fault %0b sat %0b", $time,
                         o_temp_centi_c, o_fault, o_saturated);
                n_errors++;
            end else begin
                e = pending_readings.pop_front();
                n_results++;
                if (e.fault) n_faults++;
                if (e.sat) n_sats++;
                if (o_temp_centi_c !== e.temp) begin
                    $display("%0t: temp expected %0d actual %0d", $time, e.temp, o_temp_centi_c);
                    n_errors++;
                end
                if (o_fault !== e.fault) begin
                    $display("%0t: fault expected %0b actual %0b", $time, e.fault, o_fault);
                    n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                             o_saturated);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_word(logic mode, logic [11:0] smp);
        int  gap;
        logic b;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_sample <= smp;
        forever begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
            if (!b) break;
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending_readings.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] data);
        logic r;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(negedge i_clk);
            r = o_cfg_ready;
            @(posedge i_clk);
            if (r) break;
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            ntcb_pkg::CFG_SERIES_A:  ser_a = data;
            ntcb_pkg::CFG_NOMINAL_A: nom_a = data;
            ntcb_pkg::CFG_SERIES_B:  ser_b = data;
            ntcb_pkg::CFG_NOMINAL_B: nom_b = data;
            ntcb_pkg::CFG_BETA:      beta_k = data[13:0];
            ntcb_pkg::CFG_T0:        t0_centi = data[14:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(int sa, int na, int sb, int nb, int bk, int t0);
        write_reg(ntcb_pkg::CFG_SERIES_A, sa[19:0]);
        write_reg(ntcb_pkg::CFG_NOMINAL_A, na[19:0]);
        write_reg(ntcb_pkg::CFG_SERIES_B, sb[19:0]);
        write_reg(ntcb_pkg::CFG_NOMINAL_B, nb[19:0]);
        write_reg(ntcb_pkg::CFG_BETA, bk[19:0]);
        write_reg(ntcb_pkg::CFG_T0, {5'($urandom), t0[14:0]});
    endtask

    task automatic test_reset_defaults();
        logic [11:0] edges[8] = '{12'd0, 12'd1, 12'd2, 12'd2048, 12'd4093, 12'd4094,
                                  12'd4095, 12'd2730};
        foreach (edges[i]) begin
            send_word(1'b0, edges[i]);
            send_word(1'b1, edges[i]);
        end
        settle();
    endtask

    task automatic test_register_extremes();
        load_setting(1, 1000000, 1000000, 1, 1000, -5500);
        for (int i = 0; i < 6; i++) send_word(i[0], (i < 2) ? 12'd1 : 12'd4094);
        settle();
        load_setting(1000000, 1, 1, 1000000, 10000, 15000);
        for (int i = 0; i < 6; i++) send_word(i[0], (i < 2) ? 12'd1 : 12'd4094);
        settle();
        load_setting(0, 10000, 22000, 0, 3950, 2500);
        send_word(1'b0, 12'd2000);
        send_word(1'b1, 12'd2000);
        settle();
        write_reg(ntcb_pkg::CFG_SERIES_A, 20'd10000);
        write_reg(ntcb_pkg::CFG_NOMINAL_B, 20'd20000);
        write_reg(ntcb_pkg::CFG_BETA, 20'hFC000);
        write_reg(IDX_SPARE6, 20'hFFFFF);
        write_reg(IDX_SPARE7, 20'h00001);
        send_word(1'b0, 12'd2000);
        settle();
        write_reg(ntcb_pkg::CFG_BETA, 20'd3950);
        write_reg(ntcb_pkg::CFG_T0, 20'h4000);
        send_word(1'b1, 12'd100);
        settle();
    endtask

    task automatic test_random_conversions();
        logic [11:0] smp;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                load_setting(10000, 10000, 22000, 20000, 3950, 2500);
            else if (ph == 1)
                load_setting(1, 1000000, 1000000, 1, 10000, 15000);
            else
                load_setting($urandom_range(1, 1000000), $urandom_range(1, 1000000),
                             $urandom_range(1, 1000000), $urandom_range(1, 1000000),
                             $urandom_range(1000, 10000), $urandom_range(0, 20500) - 5500);
            for (int i = 0; i < 300; i++) begin
                case ($urandom_range(0, 9))
                    0:       smp = ($urandom_range(0, 1)) ? 12'd0 : 12'd4095;
                    1:       smp = 12'($urandom_range(1, 16));
                    2:       smp = 12'($urandom_range(4080, 4094));
                    default: smp = 12'($urandom_range(1, 4094));
                endcase
                send_word(1'($urandom), smp);
            end
            settle();
        end
    endtask

    initial begin
        ser_a = 20'd10000;
        nom_a = 20'd10000;
        ser_b = 20'd22000;
        nom_b = 20'd20000;
        beta_k = 14'd3950;
        t0_centi = 15'd2500;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_conversions();
        $display("Converted %0d samples over directed and random settings.", n_words);
        $display("Results %0d, faults %0d, saturated %0d.", n_results, n_faults, n_sats);
        if (n_errors == 0 && pending_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", pending_readings.size());
        $display("status: fail");
        $finish;
    end

endmodule
